// ===== design/wjs_pkg.sv =====
// ----------------------------------------------------------------------------
// wjs_pkg
// Shared types, register indexes and helpers of the winding jump sequencer.
// ----------------------------------------------------------------------------
package wjs_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgStallLimit   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTimingAfter  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMinRun       = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStartHigh    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStartLow     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRampStep     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgRejumpLow    = 3'd6;

  // Register reset values
  localparam logic [3:0] RstStallLimit  = 4'd5;
  localparam logic [7:0] RstTimingAfter = 8'd3;
  localparam logic [7:0] RstMinRun      = 8'd4;
  localparam logic [7:0] RstStartHigh   = 8'd20;
  localparam logic [7:0] RstStartLow    = 8'd30;
  localparam logic [6:0] RstRampStep    = 7'd5;
  localparam logic [7:0] RstRejumpLow   = 8'd50;

  // Transaction opcodes
  localparam logic OpStart  = 1'b0;
  localparam logic OpSample = 1'b1;

  // Status codes shown on the result channel
  localparam logic [2:0] StatusIdle  = 3'd0;
  localparam logic [2:0] StatusWait  = 3'd1;
  localparam logic [2:0] StatusRun   = 3'd2;
  localparam logic [2:0] StatusDone  = 3'd3;
  localparam logic [2:0] StatusStall = 3'd4;

  // Sequencer phase, one-hot
  typedef enum logic [4:0] {
    PhIdle  = 5'b00001,
    PhWait  = 5'b00010,
    PhRun   = 5'b00100,
    PhDone  = 5'b01000,
    PhStall = 5'b10000
  } phase_e;

  // One result transaction
  typedef struct packed {
    logic        motor_mode;
    logic [7:0]  high_time;
    logic [7:0]  low_time;
    logic        timing_signal;
    logic        winding;
    logic [2:0]  status;
    logic [15:0] jumps_done;
  } result_t;

  function automatic logic [2:0] phase_status(phase_e ph);
    logic [2:0] st;
    case (ph)
      PhIdle:  st = StatusIdle;
      PhWait:  st = StatusWait;
      PhRun:   st = StatusRun;
      PhDone:  st = StatusDone;
      PhStall: st = StatusStall;
      default: st = StatusIdle;
    endcase
    return st;
  endfunction

endpackage

// ===== design/winding_jump_sequencer.sv =====
// ----------------------------------------------------------------------------
// winding_jump_sequencer
// Motor winding sequencer with soft-start PWM ramp, jump counting and stall
// detection.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one transaction: a start
//   (op_i = 0, with jump_target_i) or one sensor sample (op_i = 1, with
//   period_elapsed_i, motor_stopped_i, interrupter_i).
//   Each input transaction yields exactly one result transaction on the
//   output channel (out_valid_o / out_ready_i): motor drive, PWM times,
//   timing signal, winding flag, status and jump count.
//   The result is written into the output buffer as the input is accepted.
//   Throughput: one transaction per cycle unless the skid register is full;
//   each update is one combinational pass from state into result registers.
//   A two-entry output buffer lets one more input be taken while a result
//   waits; a stalled receiver blocks the input only once both are full.
//   Reset: phase idle, all counters zero, registers at their default values,
//   output buffer empty. Configuration writes (cfg_we_i) take effect at the
//   next clock edge; issue them only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module winding_jump_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [wjs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [wjs_pkg::CfgDataW-1:0]   cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic [15:0]                    jump_target_i,
  input  logic                           period_elapsed_i,
  input  logic                           motor_stopped_i,
  input  logic                           interrupter_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           motor_mode_o,
  output logic [7:0]                     high_time_o,
  output logic [7:0]                     low_time_o,
  output logic                           timing_signal_o,
  output logic                           winding_o,
  output logic [2:0]                     status_o,
  output logic [15:0]                    jumps_done_o
);

  // Configuration registers
  logic [3:0] stall_limit_q;
  logic [7:0] timing_after_q, min_run_q, start_high_q, start_low_q, rejump_low_q;
  logic [6:0] ramp_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_limit_q  <= wjs_pkg::RstStallLimit;
      timing_after_q <= wjs_pkg::RstTimingAfter;
      min_run_q      <= wjs_pkg::RstMinRun;
      start_high_q   <= wjs_pkg::RstStartHigh;
      start_low_q    <= wjs_pkg::RstStartLow;
      ramp_step_q    <= wjs_pkg::RstRampStep;
      rejump_low_q   <= wjs_pkg::RstRejumpLow;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wjs_pkg::CfgStallLimit:  stall_limit_q  <= cfg_data_i[3:0];
        wjs_pkg::CfgTimingAfter: timing_after_q <= cfg_data_i;
        wjs_pkg::CfgMinRun:      min_run_q      <= cfg_data_i;
        wjs_pkg::CfgStartHigh:   start_high_q   <= cfg_data_i;
        wjs_pkg::CfgStartLow:    start_low_q    <= cfg_data_i;
        wjs_pkg::CfgRampStep:    ramp_step_q    <= cfg_data_i[6:0];
        wjs_pkg::CfgRejumpLow:   rejump_low_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  wjs_pkg::phase_e phase_q, phase_d;
  logic        gap_seek_q, gap_seek_d;
  logic        last_intr_q, last_intr_d;
  logic [15:0] target_q, target_d;
  logic [15:0] jump_cnt_q, jump_cnt_d;
  logic [7:0]  run_per_q, run_per_d;
  logic [7:0]  since_jump_q, since_jump_d;
  logic [3:0]  stop_per_q, stop_per_d;
  logic [7:0]  pwm_high_q, pwm_high_d;
  logic [7:0]  pwm_low_q, pwm_low_d;
  logic        timing;
  logic [8:0]  high_sum;

  logic in_fire, out_fire;
  wjs_pkg::result_t res_new;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // One update pass per transaction
  always_comb begin
    phase_d      = phase_q;
    gap_seek_d   = gap_seek_q;
    last_intr_d  = last_intr_q;
    target_d     = target_q;
    jump_cnt_d   = jump_cnt_q;
    run_per_d    = run_per_q;
    since_jump_d = since_jump_q;
    stop_per_d   = stop_per_q;
    pwm_high_d   = pwm_high_q;
    pwm_low_d    = pwm_low_q;
    timing       = 1'b0;
    high_sum     = {1'b0, pwm_high_q} + {2'b00, ramp_step_q};

    if (op_i == wjs_pkg::OpStart) begin
      gap_seek_d   = (jump_target_i == 16'd0);
      target_d     = (jump_target_i == 16'd0) ? 16'd1 : jump_target_i;
      jump_cnt_d   = '0;
      run_per_d    = '0;
      since_jump_d = '0;
      stop_per_d   = '0;
      pwm_high_d   = start_high_q;
      pwm_low_d    = start_low_q;
      phase_d      = wjs_pkg::PhWait;
    end else if (phase_q == wjs_pkg::PhWait) begin
      if (motor_stopped_i) begin
        if (gap_seek_q && interrupter_i) begin
          phase_d = wjs_pkg::PhDone;
        end else begin
          last_intr_d = interrupter_i;
          phase_d     = wjs_pkg::PhRun;
          timing      = (since_jump_q >= timing_after_q);
        end
      end
    end else if (phase_q == wjs_pkg::PhRun) begin
      // period bookkeeping and ramp
      if (period_elapsed_i) begin
        run_per_d    = (run_per_q == 8'hFF) ? run_per_q : run_per_q + 8'd1;
        since_jump_d = (since_jump_q == 8'hFF) ? since_jump_q : since_jump_q + 8'd1;
        if (motor_stopped_i) begin
          stop_per_d = (stop_per_q == 4'hF) ? stop_per_q : stop_per_q + 4'd1;
          if (stop_per_d >= stall_limit_q) begin
            phase_d = wjs_pkg::PhStall;
          end
        end else begin
          stop_per_d = '0;
        end
        if (phase_d == wjs_pkg::PhRun && pwm_low_q != 8'd0) begin
          pwm_high_d = high_sum[8] ? 8'hFF : high_sum[7:0];
          pwm_low_d  = (pwm_low_q > {1'b0, ramp_step_q}) ?
                       pwm_low_q - {1'b0, ramp_step_q} : 8'd0;
        end
      end
      // edge handling and completion
      if (phase_d == wjs_pkg::PhRun) begin
        timing = (since_jump_d >= timing_after_q);
        if (interrupter_i != last_intr_q) begin
          last_intr_d = interrupter_i;
          if (interrupter_i) begin
            if (gap_seek_q) begin
              phase_d = wjs_pkg::PhDone;
            end else if (run_per_d >= min_run_q) begin
              jump_cnt_d   = jump_cnt_q + 16'd1;
              since_jump_d = '0;
              pwm_high_d   = '0;
              pwm_low_d    = rejump_low_q;
            end
          end
        end
        if (phase_d == wjs_pkg::PhRun && jump_cnt_d >= target_q) begin
          phase_d = wjs_pkg::PhDone;
        end
      end
    end

    // result of this transaction
    res_new.motor_mode    = (phase_d == wjs_pkg::PhRun);
    res_new.winding       = (phase_d == wjs_pkg::PhRun);
    res_new.high_time     = (phase_d == wjs_pkg::PhRun) ? pwm_high_d : 8'd0;
    res_new.low_time      = (phase_d == wjs_pkg::PhRun) ? pwm_low_d : 8'd0;
    res_new.timing_signal = (phase_d == wjs_pkg::PhRun) && timing;
    res_new.status        = wjs_pkg::phase_status(phase_d);
    res_new.jumps_done    = jump_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= wjs_pkg::PhIdle;
      gap_seek_q   <= 1'b0;
      last_intr_q  <= 1'b0;
      target_q     <= '0;
      jump_cnt_q   <= '0;
      run_per_q    <= '0;
      since_jump_q <= '0;
      stop_per_q   <= '0;
      pwm_high_q   <= '0;
      pwm_low_q    <= '0;
    end else if (in_fire) begin
      phase_q      <= phase_d;
      gap_seek_q   <= gap_seek_d;
      last_intr_q  <= last_intr_d;
      target_q     <= target_d;
      jump_cnt_q   <= jump_cnt_d;
      run_per_q    <= run_per_d;
      since_jump_q <= since_jump_d;
      stop_per_q   <= stop_per_d;
      pwm_high_q   <= pwm_high_d;
      pwm_low_q    <= pwm_low_d;
    end
  end

  // Two-entry output buffer: head register plus skid register
  logic              head_valid_q, skid_valid_q;
  wjs_pkg::result_t  head_q, skid_q;

  assign in_ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        head_valid_q <= in_fire;
      end
    end else if (!head_valid_q) begin
      head_valid_q <= in_fire;
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      head_q <= skid_valid_q ? skid_q : res_new;
    end else if (!head_valid_q) begin
      head_q <= res_new;
    end else if (in_fire) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o     = head_valid_q;
  assign motor_mode_o    = head_q.motor_mode;
  assign high_time_o     = head_q.high_time;
  assign low_time_o      = head_q.low_time;
  assign timing_signal_o = head_q.timing_signal;
  assign winding_o       = head_q.winding;
  assign status_o        = head_q.status;
  assign jumps_done_o    = head_q.jumps_done;

endmodule

// ===== design/wjs_checker.sv =====
// ----------------------------------------------------------------------------
// wjs_checker
// Port-level checks of the winding jump sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module wjs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        motor_mode_o,
  input logic [7:0]  high_time_o,
  input logic [7:0]  low_time_o,
  input logic        timing_signal_o,
  input logic        winding_o,
  input logic [2:0]  status_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // every accepted transaction leaves a result behind
  a_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted transaction produced no result");

  // drive and winding follow the run status
  a_run_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (winding_o == (status_o == wjs_pkg::StatusRun)) &&
                    (motor_mode_o == winding_o))
    else $error("drive flags disagree with status");

  // brake stop shows no PWM and no timing
  a_brake_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !motor_mode_o |->
      (high_time_o == 8'd0) && (low_time_o == 8'd0) && !timing_signal_o)
    else $error("PWM or timing active while braked");

endmodule

bind winding_jump_sequencer wjs_checker u_wjs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .motor_mode_o    (motor_mode_o),
  .high_time_o     (high_time_o),
  .low_time_o      (low_time_o),
  .timing_signal_o (timing_signal_o),
  .winding_o       (winding_o),
  .status_o        (status_o)
);

// ===== tb/sv/tb_winding_jump_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_winding_jump_sequencer
// Self-checking bench for the winding jump sequencer. A queue of start and
// sensor-sample commands feeds a bursty valid/ready driver. Every accepted
// transaction runs through a cycle-free model of the sequencer. The monitor
// checks each result, field by field, against the oldest predicted one. The
// receiver stalls on its own random pattern and twice holds off for a long
// stretch. Registers are reprogrammed between phases, and the phases include
// the reset defaults, then all but the ramp step at minimums and at maximums.
// ----------------------------------------------------------------------------
module tb_winding_jump_sequencer;

  localparam int QuietLimit = 3000;  // cycles with no transaction at all
  localparam int LongHold   = 300;   // receiver hold-off, fills the block

  typedef struct packed {
    logic        op;
    logic [15:0] target;
    logic        period;
    logic        stopped;
    logic        intr;
  } sensor_cmd_t;

  typedef logic [wjs_pkg::CfgDataW-1:0] cfg_word_t;

  typedef enum logic [1:0] {RxAlways, RxHalf, RxSparse, RxToggle} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                         cfg_we = 1'b0;
  logic [wjs_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [wjs_pkg::CfgDataW-1:0] cfg_data = '0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  sensor_cmd_t tx_cmd = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        motor_mode, timing_signal, winding;
  logic [7:0]  high_time, low_time;
  logic [2:0]  status;
  logic [15:0] jumps_done;

  sensor_cmd_t        sensor_cmds_q[$];
  wjs_pkg::result_t   drive_results_q[$];

  int errors = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int hold_requests = 0;

  // Model copy of the registers
  logic [3:0] lim_stall  = wjs_pkg::RstStallLimit;
  logic [7:0] lim_timing = wjs_pkg::RstTimingAfter;
  logic [7:0] lim_minrun = wjs_pkg::RstMinRun;
  logic [7:0] ld_high    = wjs_pkg::RstStartHigh;
  logic [7:0] ld_low     = wjs_pkg::RstStartLow;
  logic [6:0] ramp_amt   = wjs_pkg::RstRampStep;
  logic [7:0] ld_rejump  = wjs_pkg::RstRejumpLow;

  // Model copy of the sequencer state
  logic [2:0]  seq_phase    = wjs_pkg::StatusIdle;
  logic        seek_gap     = 1'b0;
  logic        prev_intr    = 1'b0;
  logic [15:0] target_jumps = '0;
  logic [15:0] jumps        = '0;
  logic [7:0]  runs         = '0;
  logic [7:0]  since_jump   = '0;
  logic [3:0]  stop_runs    = '0;
  logic [7:0]  pwm_hi       = '0;
  logic [7:0]  pwm_lo       = '0;

  always #4 clk_i = ~clk_i;

  winding_jump_sequencer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .op_i             (tx_cmd.op),
    .jump_target_i    (tx_cmd.target),
    .period_elapsed_i (tx_cmd.period),
    .motor_stopped_i  (tx_cmd.stopped),
    .interrupter_i    (tx_cmd.intr),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .motor_mode_o     (motor_mode),
    .high_time_o      (high_time),
    .low_time_o       (low_time),
    .timing_signal_o  (timing_signal),
    .winding_o        (winding),
    .status_o         (status),
    .jumps_done_o     (jumps_done)
  );

  // Advance the sequencer model by one transaction, return the drive outputs
  function automatic wjs_pkg::result_t advance_sequencer(sensor_cmd_t c);
    wjs_pkg::result_t r;
    logic             tmg;
    logic             run;
    logic [8:0]       hi_sum;
    tmg = 1'b0;
    if (c.op == wjs_pkg::OpStart) begin
      seek_gap     = (c.target == 16'd0);
      target_jumps = (c.target == 16'd0) ? 16'd1 : c.target;
      jumps        = '0;
      runs         = '0;
      since_jump   = '0;
      stop_runs    = '0;
      pwm_hi       = ld_high;
      pwm_lo       = ld_low;
      seq_phase    = wjs_pkg::StatusWait;
    end else if (seq_phase == wjs_pkg::StatusWait) begin
      if (c.stopped) begin
        if (seek_gap && c.intr) begin
          seq_phase = wjs_pkg::StatusDone;
        end else begin
          prev_intr = c.intr;
          seq_phase = wjs_pkg::StatusRun;
          tmg = (since_jump >= lim_timing);
        end
      end
    end else if (seq_phase == wjs_pkg::StatusRun) begin
      if (c.period) begin
        if (runs != 8'hFF) runs = runs + 8'd1;
        if (since_jump != 8'hFF) since_jump = since_jump + 8'd1;
        if (c.stopped) begin
          if (stop_runs != 4'hF) stop_runs = stop_runs + 4'd1;
          if (stop_runs >= lim_stall) seq_phase = wjs_pkg::StatusStall;
        end else begin
          stop_runs = '0;
        end
        // soft start: shift time from low to high, both saturating
        if (seq_phase == wjs_pkg::StatusRun && pwm_lo != 8'd0) begin
          hi_sum = {1'b0, pwm_hi} + {2'b00, ramp_amt};
          pwm_hi = (hi_sum > 9'd255) ? 8'hFF : hi_sum[7:0];
          pwm_lo = (pwm_lo > {1'b0, ramp_amt}) ? pwm_lo - {1'b0, ramp_amt} : 8'd0;
        end
      end
      if (seq_phase == wjs_pkg::StatusRun) begin
        tmg = (since_jump >= lim_timing);
        if (c.intr != prev_intr) begin
          prev_intr = c.intr;
          if (c.intr) begin
            if (seek_gap) begin
              seq_phase = wjs_pkg::StatusDone;
            end else if (runs >= lim_minrun) begin
              jumps      = jumps + 16'd1;
              since_jump = '0;
              pwm_hi     = '0;
              pwm_lo     = ld_rejump;
            end
          end
        end
        if (seq_phase == wjs_pkg::StatusRun && jumps >= target_jumps) begin
          seq_phase = wjs_pkg::StatusDone;
        end
      end
    end
    run = (seq_phase == wjs_pkg::StatusRun);
    r.motor_mode    = run;
    r.high_time     = run ? pwm_hi : 8'd0;
    r.low_time      = run ? pwm_lo : 8'd0;
    r.timing_signal = run ? tmg : 1'b0;
    r.winding       = run;
    r.status        = seq_phase;
    r.jumps_done    = jumps;
    return r;
  endfunction

  // Driver: bursts of transactions with random gaps between them
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        drive_results_q.push_back(advance_sequencer(tx_cmd));
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (sensor_cmds_q.size() != 0) begin
          tx_cmd <= sensor_cmds_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random ready pattern, plus long hold-offs on request
  int       hold_served = 0;
  int       hold_left = 0;
  int       pat_left = 0;
  rx_mode_e rx_mode = RxAlways;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LongHold;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_left <= $urandom_range(8, 48);
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
      end else begin
        pat_left <= pat_left - 1;
      end
      case (rx_mode)
        RxAlways: out_ready <= 1'b1;
        RxHalf:   out_ready <= 1'($urandom_range(0, 1));
        RxSparse: out_ready <= ($urandom_range(0, 3) == 0);
        default:  out_ready <= ~out_ready;
      endcase
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : result_check
    wjs_pkg::result_t got, want;
    if (rst_ni && out_valid && out_ready) begin
      got = '{motor_mode, high_time, low_time, timing_signal, winding, status, jumps_done};
      if (drive_results_q.size() == 0) begin
        errors = errors + 1;
        $display("%0t: result with nothing expected", $realtime);
      end else begin
        want = drive_results_q.pop_front();
        if (got !== want) begin
          errors = errors + 1;
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("%0t: mismatch exp mode=%0d hi=%0d lo=%0d tmg=%0d wind=%0d st=%0d jmp=%0d",
                     $realtime, want.motor_mode, want.high_time, want.low_time,
                     want.timing_signal, want.winding, want.status, want.jumps_done);
            $display("%0t:          got mode=%0d hi=%0d lo=%0d tmg=%0d wind=%0d st=%0d jmp=%0d",
                     $realtime, got.motor_mode, got.high_time, got.low_time,
                     got.timing_signal, got.winding, got.status, got.jumps_done);
          end
        end
      end
    end
  end

  // Watchdog: cycles since the last transaction of any kind
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  task automatic push_cmd(logic op, logic [15:0] tgt, logic per, logic stp, logic intr);
    sensor_cmd_t c;
    c = '{op, tgt, per, stp, intr};
    sensor_cmds_q.push_back(c);
  endtask

  task automatic write_reg(logic [wjs_pkg::CfgIdxW-1:0] idx,
                           logic [wjs_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      wjs_pkg::CfgStallLimit:  lim_stall  = val[3:0];
      wjs_pkg::CfgTimingAfter: lim_timing = val;
      wjs_pkg::CfgMinRun:      lim_minrun = val;
      wjs_pkg::CfgStartHigh:   ld_high    = val;
      wjs_pkg::CfgStartLow:    ld_low     = val;
      wjs_pkg::CfgRampStep:    ramp_amt   = val[6:0];
      wjs_pkg::CfgRejumpLow:   ld_rejump  = val;
      default: ;
    endcase
  endtask

  task automatic load_config(int stall, int tmg, int minrun, int hi, int lo, int ramp,
                             int rejump);
    write_reg(wjs_pkg::CfgStallLimit, cfg_word_t'(stall));
    write_reg(wjs_pkg::CfgTimingAfter, cfg_word_t'(tmg));
    write_reg(wjs_pkg::CfgMinRun, cfg_word_t'(minrun));
    write_reg(wjs_pkg::CfgStartHigh, cfg_word_t'(hi));
    write_reg(wjs_pkg::CfgStartLow, cfg_word_t'(lo));
    write_reg(wjs_pkg::CfgRampStep, cfg_word_t'(ramp));
    write_reg(wjs_pkg::CfgRejumpLow, cfg_word_t'(rejump));
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Block until the sender is empty and every predicted result has come
  task automatic wait_drained();
    while (sensor_cmds_q.size() != 0 || in_valid || drive_results_q.size() != 0)
      @(posedge clk_i);
  endtask

  // One start followed by a run of sensor samples with random content
  task automatic gen_winding_run(int n_samples);
    logic [15:0] tgt;
    int          pick;
    bit          stall_prone;
    logic        lvl;
    pick = $urandom_range(0, 9);
    if (pick == 0) tgt = 16'd0;
    else if (pick == 9) tgt = 16'($urandom);
    else tgt = 16'($urandom_range(1, 4));
    push_cmd(wjs_pkg::OpStart, tgt, 1'($urandom), 1'($urandom), 1'($urandom));
    stall_prone = ($urandom_range(0, 4) == 0);
    // motor still turning for a while
    repeat ($urandom_range(0, 2)) begin
      push_cmd(wjs_pkg::OpSample, 16'($urandom), 1'($urandom), 1'b0, 1'($urandom));
    end
    lvl = 1'($urandom);
    push_cmd(wjs_pkg::OpSample, 16'($urandom), 1'($urandom), 1'b1, lvl);
    repeat (n_samples) begin
      if ($urandom_range(0, 2) == 0) lvl = ~lvl;
      push_cmd(wjs_pkg::OpSample, 16'($urandom), ($urandom_range(0, 3) != 0),
               stall_prone ? ($urandom_range(0, 2) != 0) : ($urandom_range(0, 9) == 0), lvl);
    end
  endtask

  task automatic gen_noise(int n);
    repeat (n) begin
      push_cmd(1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset register values
    push_cmd(wjs_pkg::OpSample, 16'hFFFF, 1'b1, 1'b1, 1'b1);   // sample while idle
    push_cmd(wjs_pkg::OpStart, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    push_cmd(wjs_pkg::OpSample, 16'h0000, 1'b1, 1'b0, 1'b1);   // still turning, keep waiting
    push_cmd(wjs_pkg::OpSample, 16'h0000, 1'b0, 1'b1, 1'b1);   // stopped: start running
    push_cmd(wjs_pkg::OpSample, 16'h0000, 1'b1, 1'b0, 1'b0);
    push_cmd(wjs_pkg::OpSample, 16'h0000, 1'b1, 1'b0, 1'b1);   // edge too early to count
    push_cmd(wjs_pkg::OpSample, 16'h0000, 1'b1, 1'b0, 1'b0);
    push_cmd(wjs_pkg::OpSample, 16'h0000, 1'b1, 1'b0, 1'b0);
    push_cmd(wjs_pkg::OpSample, 16'h0000, 1'b0, 1'b0, 1'b1);   // counted jump, timing was high
    repeat (5) push_cmd(wjs_pkg::OpSample, 16'h0000, 1'b1, 1'b1, 1'b1); // stall
    push_cmd(wjs_pkg::OpSample, 16'hFFFF, 1'b1, 1'b1, 1'b0);   // sample in stall
    push_cmd(wjs_pkg::OpStart, 16'h0000, 1'b0, 1'b0, 1'b0);    // gap seek
    push_cmd(wjs_pkg::OpSample, 16'h0000, 1'b0, 1'b1, 1'b1);   // already in the gap: done
    push_cmd(wjs_pkg::OpSample, 16'h0000, 1'b1, 1'b1, 1'b0);   // sample in done
    push_cmd(wjs_pkg::OpStart, 16'h0000, 1'b0, 1'b0, 1'b0);
    push_cmd(wjs_pkg::OpSample, 16'h0000, 1'b0, 1'b1, 1'b0);
    push_cmd(wjs_pkg::OpSample, 16'h0000, 1'b1, 1'b0, 1'b1);   // gap found
    push_cmd(wjs_pkg::OpStart, 16'h0001, 1'b0, 1'b0, 1'b0);
    push_cmd(wjs_pkg::OpSample, 16'h0000, 1'b0, 1'b1, 1'b0);
    push_cmd(wjs_pkg::OpStart, 16'h0002, 1'b1, 1'b1, 1'b1);    // restart while running
    push_cmd(wjs_pkg::OpSample, 16'h0000, 1'b0, 1'b1, 1'b1);
    wait_drained();

    // All registers but the ramp step (one) at their minimum, stall limit zero behaves as one
    load_config(0, 0, 0, 0, 0, 1, 0);
    repeat (8) gen_winding_run($urandom_range(4, 14));
    wait_drained();

    // All registers but the ramp step (64) at their maximum: saturating counters and ramp
    load_config(15, 255, 255, 255, 255, 64, 255);
    push_cmd(wjs_pkg::OpStart, 16'd2, 1'b0, 1'b0, 1'b0);
    push_cmd(wjs_pkg::OpSample, 16'd0, 1'b1, 1'b1, 1'b0);
    repeat (262) push_cmd(wjs_pkg::OpSample, 16'($urandom), 1'b1, 1'b0, 1'b0);
    push_cmd(wjs_pkg::OpSample, 16'd0, 1'b1, 1'b0, 1'b1);
    push_cmd(wjs_pkg::OpSample, 16'd0, 1'b1, 1'b0, 1'b0);
    push_cmd(wjs_pkg::OpSample, 16'd0, 1'b0, 1'b0, 1'b1);
    push_cmd(wjs_pkg::OpStart, 16'd5, 1'b0, 1'b0, 1'b0);
    push_cmd(wjs_pkg::OpSample, 16'd0, 1'b0, 1'b1, 1'b0);
    repeat (16) push_cmd(wjs_pkg::OpSample, 16'd0, 1'b1, 1'b1, 1'b0);
    wait_drained();

    // Random register settings with random sequences
    for (int ph = 0; ph < 4; ph++) begin
      load_config((ph == 0) ? 1 : $urandom_range(1, 15), $urandom_range(0, 12),
                  $urandom_range(0, 10), $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(1, 64), $urandom_range(0, 255));
      if (ph == 1 || ph == 3) hold_requests = hold_requests + 1;
      repeat (3) begin
        if ($urandom_range(0, 4) == 0) gen_noise($urandom_range(1, 4));
        gen_winding_run($urandom_range(4, 22));
      end
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    errors = errors + drive_results_q.size();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
